>>> rtl/scfp_pkg.sv
// ----------------------------------------------------------------------------
// scfp_pkg: shared types and constants for the sync CRC-8 frame parser
// Field widths, frame constants, event codes and controller/datapath signals.
// ----------------------------------------------------------------------------
`default_nettype none
package scfp_pkg;
	localparam int FRAME_BYTES = 11;
	localparam logic [3:0] FILL_FULL = 4'(FRAME_BYTES);
	localparam logic [3:0] CRC_LAST = 4'(FRAME_BYTES - 2);
	localparam logic [7:0] SYNC_FIRST = 8'hA5;
	localparam logic [7:0] SYNC_SECOND = 8'h5A;
	localparam logic [7:0] CRC_POLY = 8'h07;
	localparam logic [7:0] CRC_INIT = 8'hFF;
	localparam logic [15:0] AGE_CEILING = 16'hFFFF;

	localparam logic [2:0] EV_NONE = 3'd0;
	localparam logic [2:0] EV_VALID = 3'd1;
	localparam logic [2:0] EV_INVALID = 3'd2;
	localparam logic [2:0] EV_VERSION = 3'd3;
	localparam logic [2:0] EV_CRC = 3'd4;

	localparam logic [1:0] REG_VERSION = 2'd0;
	localparam logic [1:0] REG_VALID_MASK = 2'd1;
	localparam logic [1:0] REG_VEL_MASK = 2'd2;
	localparam logic [1:0] REG_RECOVERY = 2'd3;

	typedef struct packed {
		logic load;      // write incoming byte at fill position
		logic drop;      // shift window down one byte
		logic clear1;    // clear lone non-sync byte
		logic crc_start; // seed CRC
		logic crc_step;  // fold one window byte
		logic accept;    // commit frame
	} cmd_t;

	typedef struct packed {
		logic [3:0] fill;
		logic       sync_ok;
		logic       lone_bad;
		logic       ver_ok;
		logic       crc_ok;
		logic       crc_last;
	} sts_t;
endpackage
`default_nettype wire

>>> rtl/scfp_datapath.sv
// ----------------------------------------------------------------------------
// scfp_datapath: frame window, CRC unit and measurement state
// Shifts the window, folds one byte per cycle into the CRC and commits frames.
// ----------------------------------------------------------------------------
`default_nettype none
module scfp_datapath import scfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire cmd_t        cmd,
	output sts_t             sts,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] rx_time_ms,
	input  wire logic [31:0] now_ms,
	input  wire logic [7:0]  cfg_version,
	input  wire logic [7:0]  cfg_valid_mask,
	input  wire logic [7:0]  cfg_vel_mask,
	input  wire logic [7:0]  cfg_recovery,
	output logic [2:0]       accept_event,
	output logic [7:0]       accept_missed,
	output logic             have_measurement,
	output logic [7:0]       seq_number,
	output logic [7:0]       src_age_ms,
	output logic signed [15:0] position,
	output logic signed [15:0] velocity,
	output logic [7:0]       flags_byte,
	output logic [31:0]      frame_end_ms,
	output logic             vel_trusted,
	output logic [15:0]      peak_age_ms,
	output logic             hold_flag
);
	localparam int FW = $clog2(FRAME_BYTES + 1);

	logic [7:0] win_q [FRAME_BYTES];
	logic [FW-1:0] fill_q;
	logic [7:0] crc_q;
	logic [3:0] crc_idx_q;
	logic [31:0] arr_q, now_q;
	logic seq_seen_q, last_valid_q;
	logic [7:0] prev_seq_q, rec_q;

	logic [7:0] crc_in, crc_next;
	logic [7:0] delta;
	logic gap, flag_ok;
	logic [7:0] rec_next;
	logic [32:0] age_wide;
	logic [15:0] age_sat;

	always_comb begin
		crc_next = crc_q ^ win_q[crc_idx_q];
		crc_in = crc_next;
		for (int b = 0; b < 8; b++) begin
			crc_in = crc_in[7] ? ((crc_in << 1) ^ CRC_POLY) : (crc_in << 1);
		end
	end

	assign sts.fill = 4'(fill_q);
	assign sts.sync_ok = (win_q[0] == SYNC_FIRST) && (win_q[1] == SYNC_SECOND);
	assign sts.lone_bad = (win_q[0] != SYNC_FIRST);
	assign sts.ver_ok = (win_q[2] == cfg_version);
	assign sts.crc_ok = (crc_q == win_q[FRAME_BYTES-1]);
	assign sts.crc_last = (crc_idx_q == CRC_LAST);

	assign delta = win_q[3] - prev_seq_q;
	assign gap = seq_seen_q && (delta != 8'd1);
	assign flag_ok = (win_q[9] & cfg_valid_mask) != 8'd0;
	always_comb begin
		rec_next = rec_q;
		if (gap) rec_next = cfg_recovery;
		else if (flag_ok && rec_q != 8'd0) rec_next = rec_q - 8'd1;
	end
	assign age_wide = {25'd0, win_q[4]} + {1'b0, now_q - arr_q} + 33'd1;
	assign age_sat = (age_wide > {17'd0, AGE_CEILING}) ? AGE_CEILING : age_wide[15:0];

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			win_q[fill_q[3:0]] <= rx_byte;
			// hold the word's times for the frame commit
			arr_q <= rx_time_ms;
			now_q <= now_ms;
		end
		if (cmd.drop) begin
			for (int i = 1; i < FRAME_BYTES; i++) win_q[i-1] <= win_q[i];
		end
		if (cmd.crc_start) begin
			crc_q <= CRC_INIT;
			crc_idx_q <= 4'd2;
		end else if (cmd.crc_step) begin
			crc_q <= crc_in;
			crc_idx_q <= crc_idx_q + 4'd1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			seq_seen_q <= 1'b0;
			prev_seq_q <= '0;
			rec_q <= '0;
			last_valid_q <= 1'b0;
			have_measurement <= 1'b0;
			seq_number <= '0;
			src_age_ms <= '0;
			position <= '0;
			velocity <= '0;
			flags_byte <= '0;
			frame_end_ms <= '0;
			vel_trusted <= 1'b0;
			peak_age_ms <= '0;
			accept_event <= EV_NONE;
			accept_missed <= '0;
		end else begin
			if (cmd.load) fill_q <= fill_q + FW'(1);
			else if (cmd.drop) fill_q <= fill_q - FW'(1);
			else if (cmd.clear1) fill_q <= '0;
			if (cmd.accept) begin
				fill_q <= '0;
				seq_seen_q <= 1'b1;
				prev_seq_q <= win_q[3];
				rec_q <= rec_next;
				accept_missed <= gap ? ((delta == 8'd0) ? 8'd1 : delta - 8'd1) : 8'd0;
				if (flag_ok) begin
					accept_event <= EV_VALID;
					last_valid_q <= 1'b1;
					have_measurement <= 1'b1;
					seq_number <= win_q[3];
					src_age_ms <= win_q[4];
					position <= {win_q[6], win_q[5]};
					velocity <= {win_q[8], win_q[7]};
					flags_byte <= win_q[9];
					frame_end_ms <= arr_q;
					vel_trusted <= ((win_q[9] & cfg_vel_mask) != 8'd0) &&
						(rec_next == 8'd0);
					if (age_sat > peak_age_ms) peak_age_ms <= age_sat;
				end else begin
					accept_event <= EV_INVALID;
					last_valid_q <= 1'b0;
				end
			end
		end
	end

	assign hold_flag = !last_valid_q;
endmodule
`default_nettype wire

>>> rtl/scfp_ctrl.sv
// ----------------------------------------------------------------------------
// scfp_ctrl: sequencer for the frame parser
// Loads a byte, hunts sync, checks version and CRC, resyncs and emits results.
// ----------------------------------------------------------------------------
`default_nettype none
module scfp_ctrl import scfp_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	output logic            out_valid,
	input  wire logic       out_ready,
	input  wire sts_t       sts,
	output cmd_t            cmd,
	output logic [2:0]      event_res
);
	typedef enum logic [2:0] {S_IDLE, S_HUNT, S_CHECK, S_CRC, S_FAIL, S_HUNT2} state_t;
	state_t state_q;
	logic [2:0] ev_q;

	assign in_ready = (state_q == S_IDLE) && !out_valid;

	always_comb begin
		cmd = '0;
		case (state_q)
			S_IDLE: cmd.load = in_valid && in_ready && (sts.fill != FILL_FULL);
			S_HUNT, S_HUNT2: begin
				if (sts.fill >= 4'd2 && !sts.sync_ok) cmd.drop = 1'b1;
				else if (sts.fill == 4'd1 && sts.lone_bad) cmd.clear1 = 1'b1;
			end
			S_CHECK: cmd.crc_start = (sts.fill == FILL_FULL) && sts.ver_ok;
			S_CRC: cmd.crc_step = 1'b1;
			S_FAIL: cmd.drop = 1'b1;
			default: cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid <= 1'b0;
			ev_q <= EV_NONE;
			event_res <= EV_NONE;
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			case (state_q)
				S_IDLE: if (in_valid && in_ready) begin
					state_q <= S_HUNT;
					ev_q <= EV_NONE;
				end
				S_HUNT: if (!(cmd.drop || cmd.clear1)) state_q <= S_CHECK;
				S_CHECK: begin
					if (sts.fill != FILL_FULL) begin
						event_res <= ev_q;
						out_valid <= 1'b1;
						state_q <= S_IDLE;
					end else if (!sts.ver_ok) begin
						ev_q <= EV_VERSION;
						state_q <= S_FAIL;
					end else state_q <= S_CRC;
				end
				S_CRC: if (sts.crc_last) state_q <= S_FAIL;
				S_FAIL: begin
					// CRC result is ready here; FAIL also hosts the accept decision
					state_q <= S_HUNT2;
				end
				S_HUNT2: if (!(cmd.drop || cmd.clear1)) begin
					event_res <= ev_q;
					out_valid <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> rtl/sync_crc8_frame_parser.sv
// Sequencing from byte accept to result valid: hunt and check when no full frame
// forms, a resync after a version failure, 8 CRC steps (one byte per cycle)
// for an accepted frame, and the CRC steps plus a resync on a CRC failure.
// Throughput: one byte in flight; ready returns the cycle after the result word
// is taken, and an output stall holds off the next byte.
// Reset: arst_n clears fill, sequence and measurement state; loads defaults.
// ----------------------------------------------------------------------------
// sync_crc8_frame_parser: top level
// Config registers, sequencer and datapath for the framed packet parser.
// ----------------------------------------------------------------------------
`default_nettype none
module sync_crc8_frame_parser import scfp_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [7:0]  rx_byte,
	input  wire logic [31:0] rx_time_ms,
	input  wire logic [31:0] now_ms,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [2:0]       event_res,
	output logic             have_measurement,
	output logic [7:0]       seq_number,
	output logic [7:0]       src_age_ms,
	output logic signed [15:0] position,
	output logic signed [15:0] velocity,
	output logic [7:0]       flags_byte,
	output logic [31:0]      frame_end_ms,
	output logic             vel_trusted,
	output logic [7:0]       missed_frames,
	output logic [15:0]      peak_age_ms,
	output logic             hold_flag
);
	logic [7:0] ver_q, vmask_q, velmask_q, rec_q;
	cmd_t cmd, cmd_dp;
	sts_t sts;
	logic [2:0] ctl_event, acc_event;
	logic [7:0] acc_missed;
	logic fail_state, acc_fire;
	logic acc_done_q;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ver_q <= 8'd1;
			vmask_q <= 8'd1;
			velmask_q <= 8'd2;
			rec_q <= 8'd3;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_VERSION: ver_q <= cfg_data;
				REG_VALID_MASK: vmask_q <= cfg_data;
				REG_VEL_MASK: velmask_q <= cfg_data;
				REG_RECOVERY: rec_q <= cfg_data;
				default: ;
			endcase
		end
	end

	scfp_ctrl u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .sts,
		.cmd, .event_res(ctl_event)
	);

	// in the fail slot after CRC: commit on a CRC match, else drop one byte
	assign fail_state = cmd.drop && sts.fill == FILL_FULL && sts.ver_ok && !cmd.load;
	assign acc_fire = fail_state && sts.crc_ok && !acc_done_q;
	always_comb begin
		cmd_dp = cmd;
		if (acc_fire) begin
			cmd_dp.drop = 1'b0;
			cmd_dp.accept = 1'b1;
		end
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) acc_done_q <= 1'b0;
		else if (cmd.load) acc_done_q <= 1'b0;
		else if (cmd_dp.accept) acc_done_q <= 1'b1;
	end

	logic crc_fail_q, acc_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_fail_q <= 1'b0;
			acc_q <= 1'b0;
		end else if (cmd.load) begin
			crc_fail_q <= 1'b0;
			acc_q <= 1'b0;
		end else if (fail_state && !acc_done_q) begin
			crc_fail_q <= !sts.crc_ok;
			acc_q <= sts.crc_ok;
		end
	end

	scfp_datapath u_dp (
		.clk, .arst_n, .cmd(cmd_dp), .sts, .rx_byte, .rx_time_ms, .now_ms,
		.cfg_version(ver_q), .cfg_valid_mask(vmask_q), .cfg_vel_mask(velmask_q),
		.cfg_recovery(rec_q), .accept_event(acc_event), .accept_missed(acc_missed),
		.have_measurement, .seq_number, .src_age_ms, .position, .velocity,
		.flags_byte, .frame_end_ms, .vel_trusted, .peak_age_ms, .hold_flag
	);

	assign event_res = acc_q ? acc_event : (crc_fail_q ? EV_CRC : ctl_event);
	assign missed_frames = acc_q ? acc_missed : 8'd0;
endmodule
`default_nettype wire

>>> rtl/scfp_checker.sv
// ----------------------------------------------------------------------------
// scfp_checker: port-level assertions for the frame parser
// Watches the handshakes and result fields of the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module scfp_checker import scfp_pkg::*; (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic [2:0] event_res,
	input wire logic [7:0] missed_frames,
	input wire logic       have_measurement,
	input wire logic [7:0] seq_number
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(event_res))
		else $error("result dropped while stalled");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("byte taken with result pending");
	a_missed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (event_res == EV_NONE || event_res == EV_VERSION ||
		event_res == EV_CRC) |-> missed_frames == 8'd0)
		else $error("missed frames outside accept");
	a_meas: assert property (@(posedge clk) disable iff (!arst_n)
		!have_measurement |-> seq_number == 8'd0) else $error("stale measurement");
endmodule

bind sync_crc8_frame_parser scfp_checker u_chk (
	.clk, .arst_n, .in_valid, .in_ready, .out_valid, .out_ready, .event_res,
	.missed_frames, .have_measurement, .seq_number
);
`default_nettype wire
